@@ rtl/core/hfd_pkg.sv @@
// hook flash detector package: phase, event and command codes, count limits, queue and result types
// no dependencies; used by hfd_front, hfd_back and hook_flash_detector
`default_nettype none

package hfd_pkg;

    localparam logic [1:0] PH_ON       = 2'd0;
    localparam logic [1:0] PH_CONF_OFF = 2'd1;
    localparam logic [1:0] PH_OFF      = 2'd2;
    localparam logic [1:0] PH_CONF_ON  = 2'd3;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FLASH = 2'd1;
    localparam logic [1:0] KIND_ON    = 2'd2;
    localparam logic [1:0] KIND_OFF   = 2'd3;

    localparam logic       CMD_TICK = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    localparam int         CNT_W           = 7;
    localparam logic [6:0] CNT_MAX         = 7'd127;
    localparam logic [6:0] FLASH_LIMIT_RST = 7'd50;

    typedef struct packed {
        logic       is_read;
        logic       in_range;
        logic [1:0] line;
        logic       hook_off;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

    typedef struct packed {
        logic [1:0] event_line;
        logic [1:0] event_kind;
        logic       start_voice;
        logic       stop_ring_voice;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/hfd_in_if.sv @@
// input channel of the hook flash detector: valid/ready with command payload
// no dependencies
`default_nettype none

interface hfd_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] line;
    logic       hook_off;

    modport source (output valid, output cmd, output line, output hook_off, input ready);
    modport sink   (input valid, input cmd, input line, input hook_off, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hfd_out_if.sv @@
// result channel of the hook flash detector: valid/ready with event payload
// no dependencies
`default_nettype none

interface hfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_line;
    logic [1:0] event_kind;
    logic       start_voice;
    logic       stop_ring_voice;

    modport source (output valid, output event_line, output event_kind,
                    output start_voice, output stop_ring_voice, input ready);
    modport sink   (input valid, input event_line, input event_kind,
                    input start_voice, input stop_ring_voice, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hfd_front.sv @@
// front end: accepts input transactions, classifies them, holds a two-entry queue
// depends on hfd_pkg and hfd_in_if
`default_nettype none

module hfd_front #(
    parameter int LINES = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    hfd_in_if.sink              i_in,
    input  wire logic           i_pop,
    output hfd_pkg::t_qhead     o_head
);

    localparam int DEPTH = 2;

    hfd_pkg::t_op r_mem [DEPTH];
    logic         r_wptr, n_wptr;
    logic         r_rptr, n_rptr;
    logic [1:0]   r_count, n_count;
    logic         w_push;
    logic         w_pop;
    hfd_pkg::t_op w_op;

    assign i_in.ready = (r_count != 2'(DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != 2'd0);

    always_comb begin
        w_op.is_read  = (i_in.cmd == hfd_pkg::CMD_READ);
        w_op.in_range = (32'(i_in.line) < LINES);
        w_op.line     = i_in.line;
        w_op.hook_off = i_in.hook_off;
    end

    always_comb begin
        n_wptr  = w_push ? ~r_wptr : r_wptr;
        n_rptr  = w_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_op;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_mem[r_rptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_count != 2'd0) |=> (r_rptr != $past(r_rptr)))
        else $error("pop did not advance read pointer");

endmodule

`default_nettype wire

@@ rtl/core/hfd_back.sv @@
// back end: per-line hook state, tick sequencer, event scan and result register
// depends on hfd_pkg and hfd_out_if
`default_nettype none

module hfd_back #(
    parameter int LINES = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [6:0]     i_flash_limit,
    input  wire hfd_pkg::t_qhead i_head,
    output logic                o_pop,
    hfd_out_if.source           o_out
);

    localparam int             LW        = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [LW-1:0]  LAST      = LW'(LINES - 1);
    localparam logic [1:0]     NONE_LINE = 2'(LINES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [LW-1:0]            r_idx, n_idx;
    logic                     r_hook, n_hook;

    logic [1:0]               r_phase [LINES];
    logic [hfd_pkg::CNT_W-1:0] r_cnt  [LINES];
    logic                     r_roh   [LINES];
    logic                     r_hcp   [LINES];
    logic                     r_fp    [LINES];

    logic [1:0]               cur_ph, n_ph;
    logic [hfd_pkg::CNT_W-1:0] cur_cnt, cnt_b, n_cnt;
    logic                     cur_roh, n_roh;
    logic                     cur_hcp, n_hcp;
    logic                     cur_fp, n_fp;
    logic                     w_we;
    logic                     w_load;
    logic                     w_out_free;
    hfd_pkg::t_result         w_res;

    logic                     r_out_valid, n_out_valid;
    hfd_pkg::t_result         r_out;

    always_comb begin
        cur_ph  = r_phase[r_idx];
        cur_cnt = r_cnt[r_idx];
        cur_roh = r_roh[r_idx];
        cur_hcp = r_hcp[r_idx];
        cur_fp  = r_fp[r_idx];
        cnt_b   = (cur_cnt == hfd_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 7'd1;

        n_ph    = cur_ph;
        n_cnt   = cur_cnt;
        n_roh   = cur_roh;
        n_hcp   = cur_hcp;
        n_fp    = cur_fp;
        w_we    = 1'b0;
        w_load  = 1'b0;
        o_pop   = 1'b0;
        n_state = r_state;
        n_idx   = r_idx;
        n_hook  = r_hook;

        w_res.event_line      = NONE_LINE;
        w_res.event_kind      = hfd_pkg::KIND_NONE;
        w_res.start_voice     = 1'b0;
        w_res.stop_ring_voice = 1'b0;

        w_out_free = !r_out_valid || o_out.ready;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid && w_out_free) begin
                    o_pop = 1'b1;
                    if (i_head.op.is_read) begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                    end else if (i_head.op.in_range) begin
                        n_state = ST_TICK;
                        n_idx   = LW'(i_head.op.line);
                        n_hook  = i_head.op.hook_off;
                    end else begin
                        // tick for a line that does not exist
                        w_load = 1'b1;
                    end
                end
            end
            ST_TICK: begin
                w_we    = 1'b1;
                w_load  = 1'b1;
                n_state = ST_IDLE;
                case (cur_ph)
                    hfd_pkg::PH_ON: begin
                        if (r_hook) begin
                            n_cnt = '0;
                            n_ph  = hfd_pkg::PH_CONF_OFF;
                        end
                    end
                    hfd_pkg::PH_CONF_OFF: begin
                        n_cnt = cnt_b;
                        if (!r_hook) begin
                            n_ph = hfd_pkg::PH_ON;
                        end else if (cnt_b > i_flash_limit) begin
                            n_roh = 1'b1;
                            n_hcp = 1'b1;
                            n_cnt = '0;
                            n_ph  = hfd_pkg::PH_OFF;
                            w_res.start_voice = 1'b1;
                        end
                    end
                    hfd_pkg::PH_OFF: begin
                        if (!r_hook) begin
                            n_cnt = '0;
                            n_ph  = hfd_pkg::PH_CONF_ON;
                        end
                    end
                    default: begin
                        n_cnt = cnt_b;
                        if (r_hook) begin
                            // short on-hook pulse
                            n_roh = 1'b1;
                            n_fp  = 1'b1;
                            n_ph  = hfd_pkg::PH_OFF;
                        end else if (cnt_b > i_flash_limit) begin
                            n_roh = 1'b0;
                            n_hcp = 1'b1;
                            n_ph  = hfd_pkg::PH_ON;
                            w_res.stop_ring_voice = 1'b1;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (cur_hcp || cur_fp) begin
                    w_we    = 1'b1;
                    w_load  = 1'b1;
                    n_hcp   = 1'b0;
                    n_fp    = 1'b0;
                    n_state = ST_IDLE;
                    w_res.event_line = 2'(r_idx);
                    if (cur_hcp) begin
                        w_res.event_kind = cur_roh ? hfd_pkg::KIND_OFF : hfd_pkg::KIND_ON;
                    end else begin
                        w_res.event_kind = hfd_pkg::KIND_FLASH;
                    end
                end else if (r_idx == LAST) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_phase[i] <= hfd_pkg::PH_ON;
                r_cnt[i]   <= '0;
                r_roh[i]   <= 1'b0;
                r_hcp[i]   <= 1'b0;
                r_fp[i]    <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (w_we) begin
                r_phase[r_idx] <= n_ph;
                r_cnt[r_idx]   <= n_cnt;
                r_roh[r_idx]   <= n_roh;
                r_hcp[r_idx]   <= n_hcp;
                r_fp[r_idx]    <= n_fp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hook <= n_hook;
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.event_line      = r_out.event_line;
    assign o_out.event_kind      = r_out.event_kind;
    assign o_out.start_voice     = r_out.start_voice;
    assign o_out.stop_ring_voice = r_out.stop_ring_voice;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten");

    a_scan_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_TICK) |-> !r_out_valid)
        else $error("result pending during sequencer work");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (32'(r_idx) < LINES))
        else $error("line index out of range");

    a_strobe_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_kind != hfd_pkg::KIND_NONE)
            |-> (!o_out.start_voice && !o_out.stop_ring_voice))
        else $error("strobe on a read result");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.start_voice && o_out.stop_ring_voice))
        else $error("both strobes set");

endmodule

`default_nettype wire

@@ rtl/core/hook_flash_detector.sv @@
// top level of the hook flash detector: config register, front queue, back sequencer
// depends on hfd_pkg, hfd_in_if, hfd_out_if, hfd_front and hfd_back
//
// usage:
//   i_in carries one transaction per command: cmd 0 is a tick with the hook
//   sample of one line, cmd 1 reads the next pending event. every input
//   transaction yields exactly one result transaction on o_out, in order.
//   i_cfg_we/i_cfg_wdata write flash_limit (reset 50); write only while idle.
// command flow:
//   a tick passes through the queue, the idle pop and the line update.
//   a read is popped, then the scan checks one line per cycle until the
//   first pending line or the last line. the back sequencer runs one
//   command at a time and pops only when the result register is free.
// reset:
//   synchronous, active low; all lines return to on-hook with counts and
//   pending flags cleared, queue and result register empty.
// stall:
//   a result holds in its register until taken; the two-entry queue keeps
//   accepting until full, then i_in.ready drops.
`default_nettype none

module hook_flash_detector #(
    parameter int LINES = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    hfd_in_if.sink          i_in,
    hfd_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_wdata
);

    logic [6:0]      r_flash_limit;
    logic            w_pop;
    hfd_pkg::t_qhead w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_limit <= hfd_pkg::FLASH_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_flash_limit <= i_cfg_wdata;
        end
    end

    hfd_front #(
        .LINES (LINES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    hfd_back #(
        .LINES (LINES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_flash_limit (r_flash_limit),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire
